### rtl/core/bounded_topk_sorted_pool_macros.svh
// assertion macros shared by the pool controller and datapath
// no dependencies; sampled on clk_i; BTSP_ASSERT is disabled while rst_ni is low
`ifndef BOUNDED_TOPK_SORTED_POOL_MACROS_SVH
`define BOUNDED_TOPK_SORTED_POOL_MACROS_SVH

// checked only out of reset
`define BTSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked during reset too
`define BTSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/btsp_pkg.sv
// shared types, codes and constants of the bounded top-k sorted pool
// no dependencies
package btsp_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned MaxResults      = 16;
  localparam int unsigned STdataW         = 72;
  localparam int unsigned MTdataW         = 144;

  localparam logic signed [31:0] ScoreMax = 32'sh7FFF_FFFF;

  localparam logic [1:0] KindPublish = 2'd0;
  localparam logic [1:0] KindRead    = 2'd1;
  localparam logic [1:0] KindClear   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       pub;
    logic       clr;
    logic       load;
    logic       has_entry;
    logic       last;
    logic [3:0] idx;
  } btsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       out_free;
    logic [4:0] read_avail;
  } btsp_stat_t;

endpackage

### rtl/core/bounded_topk_sorted_pool.sv
// bounded top-k sorted pool: publish/clear/other give one beat, loaded once the
// output register is free, and the next item is taken after that load; a read of
// k entries gives k beats, one beat a cycle while the consumer keeps up, set by
// the single output beat register. reset (rst_ni low, async) empties the
// list and drops any pending beat; entry cells are not cleared
module bounded_topk_sorted_pool import btsp_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // score[31:0], score_invalid[32], entry_tag[64:33], wanted_count[69:65], zero pad
  input  logic [STdataW-1:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // accepted[0], entry_index[4:1], out_score[36:5], out_tag[68:37],
  // stored_count[73:69], list_full[74], best_score[106:75], worst_score[138:107]
  output logic [MTdataW-1:0] m_axis_tdata,
  // has_entry[0]
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);

  btsp_cmd_t          cmd;
  btsp_stat_t         stat;
  logic               accepted, has_entry, last, list_full;
  logic [3:0]         entry_index;
  logic signed [31:0] out_score, best_score, worst_score;
  logic [31:0]        out_tag;
  logic [4:0]         stored_count;

  btsp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .kind_i         (s_axis_tuser),
    .wanted_count_i (s_axis_tdata[69:65]),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  btsp_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .score_i         (s_axis_tdata[31:0]),
    .score_invalid_i (s_axis_tdata[32]),
    .entry_tag_i     (s_axis_tdata[64:33]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .accepted_o      (accepted),
    .has_entry_o     (has_entry),
    .entry_index_o   (entry_index),
    .out_score_o     (out_score),
    .out_tag_o       (out_tag),
    .last_o          (last),
    .stored_count_o  (stored_count),
    .list_full_o     (list_full),
    .best_score_o    (best_score),
    .worst_score_o   (worst_score)
  );

  assign m_axis_tdata = {5'd0, worst_score, best_score, list_full, stored_count,
                         out_tag, out_score, entry_index, accepted};
  assign m_axis_tuser = has_entry;
  assign m_axis_tlast = last;

endmodule

### rtl/core/btsp_datapath.sv
// sorted compare-and-shift cell row, occupancy and output beat register
// depends on btsp_pkg and bounded_topk_sorted_pool_macros.svh
`include "bounded_topk_sorted_pool_macros.svh"
module btsp_datapath import btsp_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btsp_cmd_t          cmd_i,
  output btsp_stat_t         stat_o,
  input  logic signed [31:0] score_i,
  input  logic               score_invalid_i,
  input  logic [31:0]        entry_tag_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               accepted_o,
  output logic               has_entry_o,
  output logic [3:0]         entry_index_o,
  output logic signed [31:0] out_score_o,
  output logic [31:0]        out_tag_o,
  output logic               last_o,
  output logic [4:0]         stored_count_o,
  output logic               list_full_o,
  output logic signed [31:0] best_score_o,
  output logic signed [31:0] worst_score_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [31:0] score_q [CAPACITY];
  logic signed [31:0] score_d [CAPACITY];
  logic [31:0]        tag_q [CAPACITY];
  logic [31:0]        tag_d [CAPACITY];
  logic signed [31:0] sh_score [CAPACITY];
  logic [31:0]        sh_tag [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic [CAPACITY-1:0] prev_le;
  logic [CW-1:0]      occ_q, occ_d, occ_m1;
  logic               full, pub_ok, acc_q;
  logic signed [31:0] best, worst;
  logic [IW-1:0]      rd_sel;

  logic               out_valid_q;
  logic               out_acc_q, out_has_q, out_last_q, out_full_q;
  logic [3:0]         out_idx_q;
  logic signed [31:0] out_score_q, out_best_q, out_worst_q;
  logic [31:0]        out_tag_q;
  logic [4:0]         out_cnt_q;

  // each cell: stored entry is at or below the new score
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      le[j] = (CW'(j) < occ_q) && !(score_i < score_q[j]);
    end
    prev_le = CAPACITY'({le, 1'b1});
    sh_score[0] = score_q[0];
    sh_tag[0]   = tag_q[0];
    for (int j = 1; j < CAPACITY; j++) begin
      sh_score[j] = score_q[j-1];
      sh_tag[j]   = tag_q[j-1];
    end
    for (int j = 0; j < CAPACITY; j++) begin
      if (le[j]) begin
        score_d[j] = score_q[j];
        tag_d[j]   = tag_q[j];
      end else if (prev_le[j]) begin
        score_d[j] = score_i;
        tag_d[j]   = entry_tag_i;
      end else begin
        score_d[j] = sh_score[j];
        tag_d[j]   = sh_tag[j];
      end
    end
  end

  assign full   = (occ_q == CW'(CAPACITY));
  assign pub_ok = !score_invalid_i && (!full || (score_i < score_q[CAPACITY-1]));

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.clr) begin
      occ_d = '0;
    end else if (cmd_i.pub && pub_ok && !full) begin
      occ_d = occ_q + 1'b1;
    end
  end

  assign occ_m1 = occ_q - 1'b1;
  assign best   = (occ_q != '0) ? score_q[0] : ScoreMax;
  assign worst  = (occ_q != '0) ? score_q[IW'(occ_m1)] : ScoreMax;
  assign rd_sel = IW'(cmd_i.idx);

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.read_avail = (8'(occ_q) >= 8'(MaxResults)) ? 5'(MaxResults) : 5'(occ_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.take) begin
        acc_q <= cmd_i.pub && pub_ok;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pub && pub_ok) begin
      for (int j = 0; j < CAPACITY; j++) begin
        score_q[j] <= score_d[j];
        tag_q[j]   <= tag_d[j];
      end
    end
    if (cmd_i.load) begin
      out_acc_q   <= acc_q && !cmd_i.has_entry;
      out_has_q   <= cmd_i.has_entry;
      out_last_q  <= cmd_i.last;
      out_idx_q   <= cmd_i.has_entry ? cmd_i.idx : 4'd0;
      out_score_q <= cmd_i.has_entry ? score_q[rd_sel] : 32'sd0;
      out_tag_q   <= cmd_i.has_entry ? tag_q[rd_sel] : 32'd0;
      out_cnt_q   <= 5'(occ_q);
      out_full_q  <= full;
      out_best_q  <= best;
      out_worst_q <= worst;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign has_entry_o    = out_has_q;
  assign entry_index_o  = out_idx_q;
  assign out_score_o    = out_score_q;
  assign out_tag_o      = out_tag_q;
  assign last_o         = out_last_q;
  assign stored_count_o = out_cnt_q;
  assign list_full_o    = out_full_q;
  assign best_score_o   = out_best_q;
  assign worst_score_o  = out_worst_q;

  `BTSP_ASSERT(a_occ_bound, occ_q <= CW'(CAPACITY), "occupancy above capacity")
  `BTSP_ASSERT(a_clear_empties, cmd_i.clr |=> occ_q == '0, "clear left entries behind")

endmodule

### rtl/core/btsp_ctrl.sv
// controller state machine: accepts items, sequences status and read beats
// depends on btsp_pkg and bounded_topk_sorted_pool_macros.svh
`include "bounded_topk_sorted_pool_macros.svh"
module btsp_ctrl import btsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [4:0] wanted_count_i,
  input  btsp_stat_t stat_i,
  output btsp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StEmit,
    StRead
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic [4:0] k_q, k_d;
  logic [4:0] k_new;
  logic       take, rd_last;

  assign in_ready_o = (state_q == StIdle);
  assign take       = in_valid_i && in_ready_o;
  assign k_new      = (wanted_count_i < stat_i.read_avail) ? wanted_count_i : stat_i.read_avail;
  assign rd_last    = ((5'(idx_q) + 5'd1) == k_q);

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    k_d             = k_q;
    cmd_o           = '0;
    cmd_o.take      = take;
    cmd_o.idx       = idx_q;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          cmd_o.pub = (kind_i == KindPublish);
          cmd_o.clr = (kind_i == KindClear);
          state_d   = StEmit;
          if ((kind_i == KindRead) && (k_new != 5'd0)) begin
            idx_d   = 4'd0;
            k_d     = k_new;
            state_d = StRead;
          end
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = StIdle;
        end
      end
      StRead: begin
        if (stat_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.has_entry = 1'b1;
          cmd_o.last      = rd_last;
          if (rd_last) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
    end
  end

  `BTSP_ASSERT(a_load_free, cmd_o.load |-> stat_i.out_free, "beat loaded over a waiting beat")
  `BTSP_ASSERT(a_read_range, (state_q == StRead) |-> (5'(idx_q) < k_q), "read rank past count")

endmodule

### tb/tb_bounded_topk_sorted_pool.sv
// self-checking testbench of the bounded top-k sorted pool: directed and random
// publish, read, clear and unknown-kind beats against a sorted-list predictor
// depends on btsp_pkg and bounded_topk_sorted_pool
module tb_bounded_topk_sorted_pool;
  import btsp_pkg::*;

  localparam logic [1:0]  KindOther   = 2'd3;
  localparam int unsigned Capacity    = DefaultCapacity;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongStall   = 200;
  localparam int unsigned StallAtBeat = 60;
  localparam int unsigned RandomItems = 124;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] score;
    logic               bad;
    logic [31:0]        tag;
    logic [4:0]         want;
    int unsigned        gap;
    bit                 drain_first;
  } pool_op_t;

  typedef struct {
    logic               accepted;
    logic               has_entry;
    logic [3:0]         rank;
    logic signed [31:0] score;
    logic [31:0]        tag;
    logic               last;
    logic [4:0]         count;
    logic               full;
    logic signed [31:0] best;
    logic signed [31:0] worst;
  } pool_beat_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [STdataW-1:0] s_axis_tdata  = '0;
  logic [1:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MTdataW-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  pool_op_t   pending_q[$];
  pool_beat_t result_q[$];

  logic signed [31:0] held_score[Capacity];
  logic [31:0]        held_tag[Capacity];
  int unsigned        held_count = 0;

  int unsigned cycle_count = 0;
  int unsigned fail_count  = 0;
  int unsigned ops_total   = 0;
  int unsigned ops_taken   = 0;
  int unsigned tx_wait     = 0;
  int unsigned rx_wait     = 0;
  int unsigned rx_beats    = 0;
  int unsigned rx_gap;
  bit          tx_burst    = 1'b0;
  pool_op_t    tx_op;
  pool_op_t    seen_op;
  pool_beat_t  want_beat;

  bounded_topk_sorted_pool DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("** bounded_topk_sorted_pool: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic pool_beat_t status_beat(input logic acc, input logic has,
                                             input logic [3:0] rank,
                                             input logic signed [31:0] sc,
                                             input logic [31:0] tg, input logic last);
    pool_beat_t b;
    b.accepted  = acc;
    b.has_entry = has;
    b.rank      = rank;
    b.score     = sc;
    b.tag       = tg;
    b.last      = last;
    b.count     = held_count[4:0];
    b.full      = (held_count == Capacity);
    b.best      = (held_count != 0) ? held_score[0] : ScoreMax;
    b.worst     = (held_count != 0) ? held_score[held_count-1] : ScoreMax;
    return b;
  endfunction

  // new entry goes after every entry of equal or lower score
  task automatic pool_insert(input logic signed [31:0] sc, input logic [31:0] tg);
    int unsigned pos;
    pos = 0;
    while (pos < held_count && !(sc < held_score[pos])) pos++;
    for (int unsigned i = held_count; i > pos; i--) begin
      held_score[i] = held_score[i-1];
      held_tag[i]   = held_tag[i-1];
    end
    held_score[pos] = sc;
    held_tag[pos]   = tg;
    held_count++;
  endtask

  task automatic pool_step(input pool_op_t op);
    int unsigned k;
    logic took;
    took = 1'b0;
    case (op.kind)
      KindPublish: begin
        if (!op.bad) begin
          if (held_count < Capacity) begin
            pool_insert(op.score, op.tag);
            took = 1'b1;
          end else if (op.score < held_score[held_count-1]) begin
            held_count--;
            pool_insert(op.score, op.tag);
            took = 1'b1;
          end
        end
        result_q.push_back(status_beat(took, 1'b0, 4'd0, '0, '0, 1'b1));
      end
      KindRead: begin
        k = op.want;
        if (k > held_count) k = held_count;
        if (k > MaxResults) k = MaxResults;
        if (k == 0) result_q.push_back(status_beat(1'b0, 1'b0, 4'd0, '0, '0, 1'b1));
        for (int unsigned i = 0; i < k; i++)
          result_q.push_back(status_beat(1'b0, 1'b1, i[3:0], held_score[i], held_tag[i],
                                         (i + 1 == k)));
      end
      KindClear: begin
        held_count = 0;
        result_q.push_back(status_beat(1'b0, 1'b0, 4'd0, '0, '0, 1'b1));
      end
      default: begin
        result_q.push_back(status_beat(1'b0, 1'b0, 4'd0, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
  endtask

  task automatic add_op(input logic [1:0] kind, input logic signed [31:0] score,
                        input logic bad, input logic [31:0] tag, input logic [4:0] want,
                        input bit drain_first);
    pool_op_t op;
    op.kind        = kind;
    op.score       = score;
    op.bad         = bad;
    op.tag         = tag;
    op.want        = want;
    op.gap         = tx_burst ? 0 : $urandom_range(0, 8);
    op.drain_first = drain_first;
    pending_q.push_back(op);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait       <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        tx_wait       <= tx_wait - 1;
      end else if (pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_q[0].drain_first && (s_axis_tvalid || result_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        tx_op = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tx_op.kind;
        s_axis_tdata  <= {2'b00, tx_op.want, tx_op.tag, tx_op.bad, tx_op.score};
        tx_wait       <= tx_op.gap;
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
      rx_beats      <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_beats <= rx_beats + 1;
      if (rx_beats + 1 == StallAtBeat) begin
        m_axis_tready <= 1'b0;
        rx_wait       <= LongStall;
      end else begin
        rx_gap = (rx_beats >= 150 && rx_beats < 250) ? 0 : $urandom_range(0, 8);
        if (rx_gap == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          rx_wait       <= rx_gap - 1;
        end
      end
    end else if (!m_axis_tready) begin
      if (rx_wait == 0) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // monitor: predict on accepted input beats, check output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen_op.kind  = s_axis_tuser;
        seen_op.score = s_axis_tdata[31:0];
        seen_op.bad   = s_axis_tdata[32];
        seen_op.tag   = s_axis_tdata[64:33];
        seen_op.want  = s_axis_tdata[69:65];
        pool_step(seen_op);
        ops_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("output beat with no expectation");
        end else begin
          want_beat = result_q.pop_front();
          check_field("accepted", m_axis_tdata[0], want_beat.accepted);
          check_field("has_entry", m_axis_tuser, want_beat.has_entry);
          check_field("entry_index", m_axis_tdata[4:1], want_beat.rank);
          check_field("out_score", m_axis_tdata[36:5], want_beat.score);
          check_field("out_tag", m_axis_tdata[68:37], want_beat.tag);
          check_field("last", m_axis_tlast, want_beat.last);
          check_field("stored_count", m_axis_tdata[73:69], want_beat.count);
          check_field("list_full", m_axis_tdata[74], want_beat.full);
          check_field("best_score", m_axis_tdata[106:75], want_beat.best);
          check_field("worst_score", m_axis_tdata[138:107], want_beat.worst);
        end
      end
    end
  end

  initial begin
    int unsigned r;
    logic [1:0] kind;
    logic signed [31:0] sc;
    logic [4:0] want;

    // empty list, unknown kind, extremes, invalid score, ties
    add_op(KindRead, 0, 1'b0, 0, 5'd0, 1'b0);
    add_op(KindRead, 0, 1'b0, 0, 5'd5, 1'b0);
    add_op(KindClear, 0, 1'b0, 0, 5'd0, 1'b0);
    add_op(KindOther, 32'sh0000_1234, 1'b1, 32'hdead_beef, 5'd3, 1'b0);
    add_op(KindPublish, ScoreMax, 1'b0, 32'hffff_ffff, 5'd31, 1'b0);
    add_op(KindPublish, 32'sh8000_0000, 1'b0, 32'h0, 5'd0, 1'b0);
    add_op(KindPublish, 32'sh0005_0000, 1'b1, 32'h1, 5'd0, 1'b0);
    add_op(KindPublish, 0, 1'b0, 32'h0000_000a, 5'd0, 1'b0);
    add_op(KindPublish, 0, 1'b0, 32'h0000_000b, 5'd0, 1'b0);
    add_op(KindRead, 0, 1'b1, 32'hffff_ffff, 5'd31, 1'b0);
    // fill up, then equal to worst and just better than worst
    for (int i = 0; i < 12; i++)
      add_op(KindPublish, (i * 3 - 10) * 65536, 1'b0, 32'h100 + i, 5'd0, 1'b0);
    add_op(KindPublish, ScoreMax, 1'b0, 32'h0000_0bad, 5'd0, 1'b0);
    add_op(KindPublish, 32'sh7fff_fffe, 1'b0, 32'h0000_0900, 5'd0, 1'b0);
    add_op(KindRead, 0, 1'b0, 0, 5'd16, 1'b0);
    add_op(KindClear, 0, 1'b0, 0, 5'd0, 1'b0);
    add_op(KindRead, 0, 1'b0, 0, 5'd1, 1'b0);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      tx_burst = (n >= 50 && n < 80);
      r = $urandom_range(0, 99);
      if (r < 72) kind = KindPublish;
      else if (r < 93) kind = KindRead;
      else if (r < 97) kind = KindClear;
      else kind = KindOther;
      case ($urandom_range(0, 3))
        0: sc = (int'($urandom_range(0, 16)) - 8) * 65536;
        1: begin
          case ($urandom_range(0, 3))
            0: sc = ScoreMax;
            1: sc = 32'sh8000_0000;
            2: sc = 0;
            default: sc = -1;
          endcase
        end
        default: sc = $urandom;
      endcase
      want = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, 16));
      add_op(kind, sc, ($urandom_range(0, 9) == 0), $urandom, want,
             (n == 0 || n == 100));
    end
    ops_total = pending_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (ops_taken != ops_total) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** bounded_topk_sorted_pool: PASSED **");
    end else begin
      $display("** bounded_topk_sorted_pool: FAILED **");
    end
    $finish;
  end

endmodule
